FILE: rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

   typedef logic [3:0] key_type;
   typedef logic [1:0] mode_code_type;
   typedef logic [1:0] held_type;
   typedef logic [3:0] count_type;

   localparam int      CsrAddrWidth = 3;
   localparam int      CsrDataWidth = 32;

   typedef logic [CsrAddrWidth-1:0] csr_addr_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   localparam csr_addr_type CSR_MAX_FAILURES = 3'd0;

   localparam key_type   KEY_STAR = 4'd10;
   localparam key_type   KEY_HASH = 4'd11;
   localparam count_type FAIL_TOP = 4'd15;
   localparam count_type MAX_FAILURES_RESET = 4'd3;

endpackage

FILE: rtl/core/kcl_if.sv
`timescale 1ns / 1ps

interface kcl_req_if;
   logic             valid;
   logic             ready;
   kcl_pkg::key_type key;

   modport source (output valid, output key, input ready);
   modport sink (input valid, input key, output ready);
endinterface

interface kcl_rsp_if;
   logic                   valid;
   logic                   ready;
   kcl_pkg::mode_code_type mode;
   logic                   echo;
   kcl_pkg::held_type      digits_held;
   logic                   code_matched;
   logic                   code_failed;
   logic                   code_changed;
   kcl_pkg::count_type     failures;

   modport source (output valid, output mode, output echo, output digits_held,
                   output code_matched, output code_failed, output code_changed,
                   output failures, input ready);
   modport sink (input valid, input mode, input echo, input digits_held,
                 input code_matched, input code_failed, input code_changed,
                 input failures, output ready);
endinterface

FILE: rtl/core/keypad_code_lock_fsm_top.sv
`timescale 1ns / 1ps

// the result item for an accepted key is registered and shows on rsp in the next cycle
// throughput: one key per cycle while the receiver keeps taking results, set by the single state update stage
// a waiting result holds back the next key until the receiver takes it
// reset (synchronous, active high): armed, stored code all zeros, no digits held,
// failure count zero, failure limit 3, no result pending
module keypad_code_lock_fsm_top #(
   parameter int CODE_LENGTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   kcl_req_if.sink               req,
   kcl_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  kcl_pkg::csr_addr_type paddr,
   input  kcl_pkg::csr_data_type pwdata,
   output kcl_pkg::csr_data_type prdata,
   output logic                  pready
);
   import kcl_pkg::*;

   localparam int PosW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   typedef logic [PosW-1:0] pos_type;

   typedef enum logic [1:0] {
      MODE_ARMED    = 2'd0,
      MODE_DISARMED = 2'd1,
      MODE_CHANGE   = 2'd2,
      MODE_ALARM    = 2'd3
   } mode_type;

   mode_type      mode_ff, mode_in;
   pos_type       pos_ff, pos_in;
   count_type     fail_ff, fail_in;
   count_type     max_fail_ff, max_fail_in;
   key_type       code_ff [CODE_LENGTH];
   key_type       code_in [CODE_LENGTH];
   key_type       entry_ff [CODE_LENGTH];
   key_type       entry_in [CODE_LENGTH];

   logic          rsp_valid_ff, rsp_valid_in;
   mode_code_type rsp_mode_ff;
   logic          rsp_echo_ff;
   held_type      rsp_held_ff;
   logic          rsp_matched_ff;
   logic          rsp_failed_ff;
   logic          rsp_changed_ff;
   count_type     rsp_fail_ff;

   logic          take;
   logic          key_ok;
   logic          last;
   logic          same;
   logic          echo;
   logic          matched;
   logic          failed;
   logic          changed;
   count_type     fail_up;
   logic [PosW+1:0] pos_ext;
   logic          csr_write;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign key_ok    = req.key <= KEY_HASH;
   assign last      = pos_ff == pos_type'(CODE_LENGTH - 1);
   assign fail_up   = (fail_ff < FAIL_TOP) ? fail_ff + 4'd1 : fail_ff;
   assign pos_ext   = {2'b00, pos_in};

   // entry compare with the incoming key as the final digit
   always_comb begin
      same = 1'b1;
      for (int n = 0; n < CODE_LENGTH; n++) begin
         if (n == CODE_LENGTH - 1) begin
            if (req.key != code_ff[n]) same = 1'b0;
         end else begin
            if (entry_ff[n] != code_ff[n]) same = 1'b0;
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      fail_in  = fail_ff;
      code_in  = code_ff;
      entry_in = entry_ff;
      echo     = 1'b0;
      matched  = 1'b0;
      failed   = 1'b0;
      changed  = 1'b0;
      if (take && key_ok) begin
         unique case (mode_ff)
            MODE_DISARMED: begin
               if (req.key == KEY_STAR) begin
                  pos_in  = '0;
                  mode_in = MODE_ARMED;
               end else if (req.key == KEY_HASH) begin
                  pos_in  = '0;
                  mode_in = MODE_CHANGE;
               end
            end
            MODE_ARMED, MODE_CHANGE, MODE_ALARM: begin
               echo = 1'b1;
               for (int n = 0; n < CODE_LENGTH; n++) begin
                  if (pos_ff == pos_type'(n)) entry_in[n] = req.key;
               end
               if (last) begin
                  pos_in = '0;
                  if (mode_ff == MODE_CHANGE) begin
                     for (int n = 0; n < CODE_LENGTH; n++) begin
                        code_in[n] = (n == CODE_LENGTH - 1) ? req.key : entry_ff[n];
                     end
                     fail_in = '0;
                     mode_in = MODE_ARMED;
                     changed = 1'b1;
                  end else if (same) begin
                     fail_in = '0;
                     mode_in = MODE_DISARMED;
                     matched = 1'b1;
                  end else begin
                     failed = 1'b1;
                     if (mode_ff == MODE_ARMED) begin
                        fail_in = fail_up;
                        if (fail_up >= max_fail_ff) mode_in = MODE_ALARM;
                     end
                  end
               end else begin
                  pos_in = pos_ff + pos_type'(1);
               end
            end
         endcase
      end
   end

   assign csr_write    = psel && penable && pwrite && pready;
   assign max_fail_in  = (csr_write && paddr[2] == CSR_MAX_FAILURES[2]) ?
                         pwdata[3:0] : max_fail_ff;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ARMED;
         pos_ff       <= '0;
         fail_ff      <= '0;
         max_fail_ff  <= MAX_FAILURES_RESET;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < CODE_LENGTH; n++) code_ff[n] <= '0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         fail_ff      <= fail_in;
         max_fail_ff  <= max_fail_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
         entry_ff     <= entry_in;
         if (take) begin
            rsp_mode_ff    <= mode_code_type'(mode_in);
            rsp_echo_ff    <= echo;
            rsp_held_ff    <= pos_ext[1:0];
            rsp_matched_ff <= matched;
            rsp_failed_ff  <= failed;
            rsp_changed_ff <= changed;
            rsp_fail_ff    <= fail_in;
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mode         = rsp_mode_ff;
   assign rsp.echo         = rsp_echo_ff;
   assign rsp.digits_held  = rsp_held_ff;
   assign rsp.code_matched = rsp_matched_ff;
   assign rsp.code_failed  = rsp_failed_ff;
   assign rsp.code_changed = rsp_changed_ff;
   assign rsp.failures     = rsp_fail_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_MAX_FAILURES[2]) ?
                   {{(CsrDataWidth - 4){1'b0}}, max_fail_ff} : '0;

   // at most one outcome per item
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot0({rsp.code_matched, rsp.code_failed, rsp.code_changed}))
      else $error("more than one outcome flag set");

   // a finished entry is always a shown symbol and leaves no digits held
   a_outcome_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.code_matched || rsp.code_failed || rsp.code_changed)) |->
      (rsp.echo && rsp.digits_held == 2'd0))
      else $error("outcome without a finished entry");

   // a match disarms and clears the failure count
   a_match_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.code_matched) |->
      (rsp.mode == mode_code_type'(MODE_DISARMED) && rsp.failures == 4'd0))
      else $error("match did not disarm");

   // storing a new code re-arms the lock
   a_change_arms: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.code_changed) |->
      (rsp.mode == mode_code_type'(MODE_ARMED) && rsp.failures == 4'd0))
      else $error("code change did not re-arm");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import kcl_pkg::*;

   localparam mode_code_type MODE_ARMED    = 2'd0;
   localparam mode_code_type MODE_DISARMED = 2'd1;
   localparam mode_code_type MODE_CHANGE   = 2'd2;
   localparam mode_code_type MODE_ALARM    = 2'd3;
   localparam int            CodeLength    = 4;
   localparam int            RandomItems   = 380;

   typedef key_type [CodeLength-1:0] code_word_t;

   typedef struct packed {
      mode_code_type mode;
      logic          echo;
      held_type      digits_held;
      logic          code_matched;
      logic          code_failed;
      logic          code_changed;
      count_type     failures;
   } lock_result_t;

   logic         clock = 1'b0;
   logic         reset;
   logic         psel;
   logic         penable;
   logic         pwrite;
   csr_addr_type paddr;
   csr_data_type pwdata;
   csr_data_type prdata;
   logic         pready;

   kcl_req_if req_ch ();
   kcl_rsp_if rsp_ch ();

   keypad_code_lock_fsm_top dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // lock state as predicted
   code_word_t    stored_code;
   code_word_t    entry_syms;
   int            held_pos;
   count_type     fail_count;
   mode_code_type lock_mode;
   count_type     fail_limit;

   lock_result_t lock_results_q[$];
   int           mismatches;
   int           items_sent;
   int           burst_left;
   bit           gaps_on;
   logic         hold_off;
   logic [6:0]   stall_phase = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lock_result_t advance_lock(key_type k);
      lock_result_t r;
      r = '0;
      if (k <= KEY_HASH) begin
         if (lock_mode == MODE_DISARMED) begin
            if (k == KEY_STAR) begin
               held_pos = 0;
               lock_mode = MODE_ARMED;
            end else if (k == KEY_HASH) begin
               held_pos = 0;
               lock_mode = MODE_CHANGE;
            end
         end else begin
            r.echo = 1'b1;
            entry_syms[held_pos] = k;
            held_pos++;
            if (held_pos >= CodeLength) begin
               held_pos = 0;
               if (lock_mode == MODE_CHANGE) begin
                  stored_code = entry_syms;
                  fail_count = '0;
                  lock_mode = MODE_ARMED;
                  r.code_changed = 1'b1;
               end else if (entry_syms == stored_code) begin
                  fail_count = '0;
                  lock_mode = MODE_DISARMED;
                  r.code_matched = 1'b1;
               end else begin
                  r.code_failed = 1'b1;
                  if (lock_mode == MODE_ARMED) begin
                     if (fail_count < FAIL_TOP) fail_count++;
                     if (fail_count >= fail_limit) lock_mode = MODE_ALARM;
                  end
               end
            end
         end
      end
      r.mode = lock_mode;
      r.digits_held = held_pos[1:0];
      r.failures = fail_count;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      lock_result_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (lock_results_q.size() == 0) begin
            $display("%0t result item with none expected, mode %0d", $time, rsp_ch.mode);
            mismatches++;
         end else begin
            want = lock_results_q.pop_front();
            check_field("mode", want.mode, rsp_ch.mode);
            check_field("echo", want.echo, rsp_ch.echo);
            check_field("digits_held", want.digits_held, rsp_ch.digits_held);
            check_field("code_matched", want.code_matched, rsp_ch.code_matched);
            check_field("code_failed", want.code_failed, rsp_ch.code_failed);
            check_field("code_changed", want.code_changed, rsp_ch.code_changed);
            check_field("failures", want.failures, rsp_ch.failures);
         end
      end
   end

   // receiver stalls at random, with a stall-free stretch while stall_phase[6] is set
   always @(posedge clock) begin
      stall_phase <= stall_phase + 7'd1;
      if (hold_off)
         rsp_ch.ready <= 1'b0;
      else if (stall_phase[6])
         rsp_ch.ready <= 1'b1;
      else
         rsp_ch.ready <= ($urandom_range(0, 2) != 0);
   end

   task automatic send_key(input key_type k);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 4) : 0;
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.key <= k;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      lock_results_q.push_back(advance_lock(k));
      items_sent++;
   endtask

   task automatic send_entry(input code_word_t c);
      for (int i = 0; i < CodeLength; i++) send_key(c[i]);
   endtask

   function automatic code_word_t random_code();
      code_word_t c;
      for (int i = 0; i < CodeLength; i++) c[i] = key_type'($urandom_range(0, 11));
      return c;
   endfunction

   function automatic code_word_t wrong_code();
      code_word_t c;
      c = random_code();
      if (c == stored_code) c[$urandom_range(0, CodeLength - 1)] ^= 4'd1;
      return c;
   endfunction

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (lock_results_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_failure_limit(input count_type lim);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_MAX_FAILURES;
      pwdata <= csr_data_type'(lim);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      fail_limit = lim;
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== csr_data_type'(lim)) begin
         $display("%0t max_failures readback expected %0d actual %0d", $time, lim, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_directed();
      code_word_t c;
      send_key(4'd12);
      send_key(4'd15);
      send_entry({4'd4, 4'd3, 4'd2, 4'd1});
      send_key(4'd13);
      send_entry('0);
      send_key(4'd5);
      send_key(4'd14);
      send_key(KEY_HASH);
      send_key(4'd12);
      c = {4'd9, KEY_HASH, KEY_STAR, 4'd9};
      send_entry(c);
      send_entry(c);
      send_key(KEY_STAR);
   endtask

   // run misses up to the alarm, one miss in alarm, then unlock and re-arm
   task automatic test_failure_limit(input count_type lim);
      int tries;
      wait_idle();
      set_failure_limit(lim);
      tries = 0;
      while (lock_mode != MODE_ALARM && tries < 17) begin
         send_entry(wrong_code());
         tries++;
      end
      send_entry(wrong_code());
      send_entry(stored_code);
      send_key(KEY_STAR);
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (60) @(posedge clock);
            hold_off <= 1'b0;
         end
         repeat (30) send_key(key_type'($urandom_range(0, 15)));
      join
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      int pick;
      int stop_at;
      int next_cfg;
      stop_at = items_sent + RandomItems;
      next_cfg = items_sent + 110;
      while (items_sent < stop_at) begin
         if (items_sent >= next_cfg) begin
            wait_idle();
            set_failure_limit(count_type'($urandom_range(0, 15)));
            next_cfg = items_sent + 110;
         end
         pick = $urandom_range(0, 99);
         case (lock_mode)
            MODE_DISARMED: begin
               if (pick < 40)
                  send_key(KEY_STAR);
               else if (pick < 75)
                  send_key(KEY_HASH);
               else if (pick < 90)
                  send_key(key_type'($urandom_range(0, 9)));
               else
                  send_key(key_type'($urandom_range(12, 15)));
            end
            MODE_CHANGE: begin
               if (held_pos != 0)
                  send_key(key_type'($urandom_range(0, 11)));
               else if (pick < 88)
                  send_entry(random_code());
               else
                  send_key(key_type'($urandom_range(12, 15)));
            end
            default: begin
               if (held_pos != 0)
                  send_key(key_type'($urandom_range(0, 11)));
               else if (pick < 45)
                  send_entry(stored_code);
               else if (pick < 80)
                  send_entry(wrong_code());
               else if (pick < 90)
                  send_key(key_type'($urandom_range(0, 11)));
               else
                  send_key(key_type'($urandom_range(12, 15)));
            end
         endcase
      end
   endtask

   initial begin
      int drain;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.key = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_off = 1'b0;
      gaps_on = 1'b1;
      burst_left = 0;
      items_sent = 0;
      mismatches = 0;
      stored_code = '0;
      entry_syms = '0;
      held_pos = 0;
      fail_count = '0;
      lock_mode = MODE_ARMED;
      fail_limit = MAX_FAILURES_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_failure_limit(4'd1);
      test_failure_limit(4'd15);
      test_failure_limit(4'd0);
      test_failure_limit(MAX_FAILURES_RESET);
      test_backpressure();
      test_random();

      req_ch.valid <= 1'b0;
      drain = 0;
      while (lock_results_q.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4) @(posedge clock);
      if (lock_results_q.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, lock_results_q.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #3000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: keypad_code_lock_fsm_top.f
rtl/core/kcl_pkg.sv
rtl/core/kcl_if.sv
rtl/core/keypad_code_lock_fsm_top.sv
tb/tb.sv
